// ===== src/tsrf_pkg.sv =====
`timescale 1ns / 1ps

package tsrf_pkg;

   // Bus event codes carried in the operation field
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_OTHER = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       bad_address;
   } rsp_type;

   // One bus event handed from the input stage to the register bank
   typedef struct packed {
      logic    go;
      req_type item;
   } step_type;

   // Readings supplied over the configuration port
   typedef struct packed {
      logic [7:0]  local_reading;
      logic [15:0] remote_reading;
   } cfg_type;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic CSR_IDX_LOCAL  = 1'b0;
   localparam logic CSR_IDX_REMOTE = 1'b1;

   localparam logic [7:0]  LOCAL_READING_RESET  = 8'd40;
   localparam logic [15:0] REMOTE_READING_RESET = 16'h1900;
   localparam logic [7:0]  MAKER_CODE           = 8'h41;
   localparam logic [7:0]  REVISION_CODE        = 8'h57;

   localparam logic [7:0]  CONFIG_RESET         = 8'h00;
   localparam logic [7:0]  RATE_RESET           = 8'h08;
   localparam logic [7:0]  LOCAL_HIGH_RESET     = 8'h55;
   localparam logic [7:0]  LOCAL_LOW_RESET      = 8'h00;
   localparam logic [15:0] REMOTE_HIGH_RESET    = 16'h5500;
   localparam logic [15:0] REMOTE_LOW_RESET     = 16'h0000;
   localparam logic [15:0] REMOTE_OFFSET_RESET  = 16'h0000;
   localparam logic [7:0]  REMOTE_CRIT_RESET    = 8'h6C;
   localparam logic [7:0]  LOCAL_CRIT_RESET     = 8'h55;
   localparam logic [7:0]  CRIT_HYST_RESET      = 8'h0A;
   localparam logic [7:0]  ALERT_COUNT_RESET    = 8'h01;

   // Register map
   localparam logic [7:0] ADDR_LOCAL_TEMP        = 8'h00;
   localparam logic [7:0] ADDR_REMOTE_TEMP_HI    = 8'h01;
   localparam logic [7:0] ADDR_STATUS            = 8'h02;
   localparam logic [7:0] ADDR_CONFIG_RD         = 8'h03;
   localparam logic [7:0] ADDR_RATE_RD           = 8'h04;
   localparam logic [7:0] ADDR_LOCAL_HIGH_RD     = 8'h05;
   localparam logic [7:0] ADDR_LOCAL_LOW_RD      = 8'h06;
   localparam logic [7:0] ADDR_REMOTE_HIGH_HI_RD = 8'h07;
   localparam logic [7:0] ADDR_REMOTE_LOW_HI_RD  = 8'h08;
   localparam logic [7:0] ADDR_CONFIG_WR         = 8'h09;
   localparam logic [7:0] ADDR_RATE_WR           = 8'h0A;
   localparam logic [7:0] ADDR_LOCAL_HIGH_WR     = 8'h0B;
   localparam logic [7:0] ADDR_LOCAL_LOW_WR      = 8'h0C;
   localparam logic [7:0] ADDR_REMOTE_HIGH_HI_WR = 8'h0D;
   localparam logic [7:0] ADDR_REMOTE_LOW_HI_WR  = 8'h0E;
   localparam logic [7:0] ADDR_ONE_SHOT          = 8'h0F;
   localparam logic [7:0] ADDR_REMOTE_TEMP_LO    = 8'h10;
   localparam logic [7:0] ADDR_OFFSET_HI         = 8'h11;
   localparam logic [7:0] ADDR_OFFSET_LO         = 8'h12;
   localparam logic [7:0] ADDR_REMOTE_HIGH_LO    = 8'h13;
   localparam logic [7:0] ADDR_REMOTE_LOW_LO     = 8'h14;
   localparam logic [7:0] ADDR_REMOTE_CRIT       = 8'h19;
   localparam logic [7:0] ADDR_LOCAL_CRIT        = 8'h20;
   localparam logic [7:0] ADDR_CRIT_HYST         = 8'h21;
   localparam logic [7:0] ADDR_ALERT_COUNT       = 8'h22;
   localparam logic [7:0] ADDR_MAKER_ID          = 8'hFE;
   localparam logic [7:0] ADDR_REVISION_ID       = 8'hFF;

endpackage

// ===== src/tsrf_csr.sv =====
`timescale 1ns / 1ps

module tsrf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsrf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsrf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsrf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output tsrf_pkg::cfg_type                    cfg
);
   import tsrf_pkg::*;

   logic [7:0]  local_reading_ff, local_reading_in;
   logic [15:0] remote_reading_ff, remote_reading_in;
   logic        write_en;
   logic        reg_index;

   // Registers sit four bytes apart, so bit 2 selects between them.
   assign reg_index  = csr_paddr[2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      local_reading_in  = local_reading_ff;
      remote_reading_in = remote_reading_ff;
      if (write_en) begin
         unique case (reg_index)
            CSR_IDX_LOCAL:  local_reading_in  = csr_pwdata[7:0];
            CSR_IDX_REMOTE: remote_reading_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         CSR_IDX_LOCAL:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, local_reading_ff};
         CSR_IDX_REMOTE: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, remote_reading_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_reading_ff  <= LOCAL_READING_RESET;
         remote_reading_ff <= REMOTE_READING_RESET;
      end else begin
         local_reading_ff  <= local_reading_in;
         remote_reading_ff <= remote_reading_in;
      end
   end

   assign cfg.local_reading  = local_reading_ff;
   assign cfg.remote_reading = remote_reading_ff;

endmodule

// ===== src/tsrf_regs.sv =====
`timescale 1ns / 1ps

module tsrf_regs (
   input  logic               clock,
   input  logic               reset,
   input  tsrf_pkg::step_type step,
   input  tsrf_pkg::cfg_type  cfg,
   output tsrf_pkg::rsp_type  result
);
   import tsrf_pkg::*;

   logic        expect_pointer_ff, expect_pointer_in;
   logic [7:0]  pointer_ff, pointer_in;
   logic [7:0]  config_byte_ff, config_byte_in;
   logic [7:0]  rate_byte_ff, rate_byte_in;
   logic [7:0]  local_high_ff, local_high_in;
   logic [7:0]  local_low_ff, local_low_in;
   logic [15:0] remote_high_ff, remote_high_in;
   logic [15:0] remote_low_ff, remote_low_in;
   logic [15:0] remote_offset_ff, remote_offset_in;
   logic [7:0]  remote_crit_ff, remote_crit_in;
   logic [7:0]  local_crit_ff, local_crit_in;
   logic [7:0]  crit_hyst_ff, crit_hyst_in;
   logic [7:0]  alert_count_ff, alert_count_in;

   logic [7:0]  rd_byte;
   logic        rd_hit;
   logic        wr_hit;
   logic [7:0]  wr_byte;

   assign wr_byte = step.item.data_byte;

   // Read decode at the current pointer
   always_comb begin
      rd_hit = 1'b1;
      unique case (pointer_ff)
         ADDR_LOCAL_TEMP:        rd_byte = cfg.local_reading;
         ADDR_REMOTE_TEMP_HI:    rd_byte = cfg.remote_reading[15:8];
         ADDR_STATUS:            rd_byte = '0;
         ADDR_CONFIG_RD:         rd_byte = config_byte_ff;
         ADDR_RATE_RD:           rd_byte = rate_byte_ff;
         ADDR_LOCAL_HIGH_RD:     rd_byte = local_high_ff;
         ADDR_LOCAL_LOW_RD:      rd_byte = local_low_ff;
         ADDR_REMOTE_HIGH_HI_RD: rd_byte = remote_high_ff[15:8];
         ADDR_REMOTE_LOW_HI_RD:  rd_byte = remote_low_ff[15:8];
         ADDR_REMOTE_TEMP_LO:    rd_byte = cfg.remote_reading[7:0];
         ADDR_OFFSET_HI:         rd_byte = remote_offset_ff[15:8];
         ADDR_OFFSET_LO:         rd_byte = remote_offset_ff[7:0];
         ADDR_REMOTE_HIGH_LO:    rd_byte = remote_high_ff[7:0];
         ADDR_REMOTE_LOW_LO:     rd_byte = remote_low_ff[7:0];
         ADDR_REMOTE_CRIT:       rd_byte = remote_crit_ff;
         ADDR_LOCAL_CRIT:        rd_byte = local_crit_ff;
         ADDR_CRIT_HYST:         rd_byte = crit_hyst_ff;
         ADDR_ALERT_COUNT:       rd_byte = alert_count_ff;
         ADDR_MAKER_ID:          rd_byte = MAKER_CODE;
         ADDR_REVISION_ID:       rd_byte = REVISION_CODE;
         default: begin
            rd_byte = '0;
            rd_hit  = 1'b0;
         end
      endcase
   end

   // Event handling and register update
   always_comb begin
      expect_pointer_in = expect_pointer_ff;
      pointer_in        = pointer_ff;
      config_byte_in    = config_byte_ff;
      rate_byte_in      = rate_byte_ff;
      local_high_in     = local_high_ff;
      local_low_in      = local_low_ff;
      remote_high_in    = remote_high_ff;
      remote_low_in     = remote_low_ff;
      remote_offset_in  = remote_offset_ff;
      remote_crit_in    = remote_crit_ff;
      local_crit_in     = local_crit_ff;
      crit_hyst_in      = crit_hyst_ff;
      alert_count_in    = alert_count_ff;
      wr_hit            = 1'b1;
      result            = '0;

      if (step.go) begin
         unique case (step.item.operation)
            OP_START: expect_pointer_in = 1'b1;
            OP_OTHER: ;
            OP_WRITE: begin
               if (expect_pointer_ff) begin
                  pointer_in        = wr_byte;
                  expect_pointer_in = 1'b0;
               end else begin
                  unique case (pointer_ff)
                     ADDR_CONFIG_WR:         config_byte_in = wr_byte;
                     ADDR_RATE_WR:           rate_byte_in   = wr_byte;
                     ADDR_LOCAL_HIGH_WR:     local_high_in  = wr_byte;
                     ADDR_LOCAL_LOW_WR:      local_low_in   = wr_byte;
                     ADDR_REMOTE_HIGH_HI_WR: remote_high_in[15:8] = wr_byte;
                     ADDR_REMOTE_LOW_HI_WR:  remote_low_in[15:8]  = wr_byte;
                     ADDR_ONE_SHOT:          ;
                     ADDR_OFFSET_HI:         remote_offset_in[15:8] = wr_byte;
                     ADDR_OFFSET_LO:         remote_offset_in[7:0]  = wr_byte;
                     ADDR_REMOTE_HIGH_LO:    remote_high_in[7:0]    = wr_byte;
                     ADDR_REMOTE_LOW_LO:     remote_low_in[7:0]     = wr_byte;
                     ADDR_REMOTE_CRIT:       remote_crit_in = wr_byte;
                     ADDR_LOCAL_CRIT:        local_crit_in  = wr_byte;
                     ADDR_CRIT_HYST:         crit_hyst_in   = wr_byte;
                     ADDR_ALERT_COUNT:       alert_count_in = wr_byte;
                     default:                wr_hit = 1'b0;
                  endcase
                  result.bad_address = !wr_hit;
                  pointer_in         = pointer_ff + 8'd1;
               end
            end
            OP_READ: begin
               result.read_valid  = 1'b1;
               result.read_data   = rd_byte;
               result.bad_address = !rd_hit;
               pointer_in         = pointer_ff + 8'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_pointer_ff <= 1'b1;
         pointer_ff        <= '0;
         config_byte_ff    <= CONFIG_RESET;
         rate_byte_ff      <= RATE_RESET;
         local_high_ff     <= LOCAL_HIGH_RESET;
         local_low_ff      <= LOCAL_LOW_RESET;
         remote_high_ff    <= REMOTE_HIGH_RESET;
         remote_low_ff     <= REMOTE_LOW_RESET;
         remote_offset_ff  <= REMOTE_OFFSET_RESET;
         remote_crit_ff    <= REMOTE_CRIT_RESET;
         local_crit_ff     <= LOCAL_CRIT_RESET;
         crit_hyst_ff      <= CRIT_HYST_RESET;
         alert_count_ff    <= ALERT_COUNT_RESET;
      end else begin
         expect_pointer_ff <= expect_pointer_in;
         pointer_ff        <= pointer_in;
         config_byte_ff    <= config_byte_in;
         rate_byte_ff      <= rate_byte_in;
         local_high_ff     <= local_high_in;
         local_low_ff      <= local_low_in;
         remote_high_ff    <= remote_high_in;
         remote_low_ff     <= remote_low_in;
         remote_offset_ff  <= remote_offset_in;
         remote_crit_ff    <= remote_crit_in;
         local_crit_ff     <= local_crit_in;
         crit_hyst_ff      <= crit_hyst_in;
         alert_count_ff    <= alert_count_in;
      end
   end

   // A pointer byte loads the pointer verbatim and disarms the pointer load.
   assert property (@(posedge clock) disable iff (reset)
      step.go && step.item.operation == OP_WRITE && expect_pointer_ff
      |=> pointer_ff == $past(step.item.data_byte) && !expect_pointer_ff)
      else $error("pointer byte not loaded");

   // Without an event being processed the pointer state must not move.
   assert property (@(posedge clock) disable iff (reset)
      !step.go |=> $stable(pointer_ff) && $stable(expect_pointer_ff))
      else $error("pointer state changed without an event");

endmodule

// ===== src/i2c_temp_sensor_register_file.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   tsrf_pkg::req_type (operation, data_byte)
// rsp_      out        rsp_valid/rsp_stall   tsrf_pkg::rsp_type (read_data, read_valid,
//                                            bad_address)
// csr_      in         APB write/read        local_reading at 0x0, remote_reading at 0x4
//
// Every bus event passes through the input register and then the result
// register, where its result is held until the result side takes it; a new
// beat can be taken in every cycle while the result side does not stall.
// Synchronous reset restores the device registers to their power-on values and
// empties both stages. A stall on the result side holds the result register;
// the input register then holds its beat and req_stall rises until space frees.

module i2c_temp_sensor_register_file (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tsrf_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tsrf_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsrf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsrf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsrf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import tsrf_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff, in_item_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_payload_ff, rsp_payload_in;
   logic     out_free;
   logic     advance;
   logic     req_take;
   step_type step;
   cfg_type  cfg;
   rsp_type  result;

   // The result register can take a new beat when it is empty or being drained
   // this cycle; the input register then hands its beat across.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign step.go   = advance;
   assign step.item = in_item_ff;

   tsrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsrf_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .result (result)
   );

   // Input register: loaded on an accepted beat, emptied when it advances.
   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_item_in  = req_payload;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: holds while stalled, otherwise takes the new result.
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (advance) begin
         rsp_payload_in = result;
         rsp_valid_in   = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff     <= in_item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A beat that leaves the input register must land in the result register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat did not reach the result register");

   // Only a read answer may carry data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.read_valid |-> rsp_payload_ff.read_data == '0)
      else $error("read data present on a non-read result");

endmodule

// ===== verif/i2c_temp_sensor_register_file_tb.sv =====
`timescale 1ns / 1ps

module i2c_temp_sensor_register_file_tb;
   import tsrf_pkg::*;

   logic clock;
   logic reset = 1'b1;

   // Request channel: bus events towards the register file.
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;

   // Result channel: one beat per bus event.
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Configuration port, driven only while both channels are quiet.
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   i2c_temp_sensor_register_file uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bus events waiting to be offered, and the replies that accepted events
   // have earned but which have not yet come back from the block.
   req_type    bus_events [$];
   rsp_type    pending_replies [$];
   logic [7:0] reg_map [$];

   int failures = 0;
   int issued = 0;

   // Sender burst shaping and receiver stall pattern.
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   // Our own copy of the device registers. The pointer state and the
   // writable registers follow the bus events; the two readings follow the
   // configuration port.
   logic        arm_pointer;
   logic [7:0]  reg_ptr;
   logic [7:0]  dev_config;
   logic [7:0]  dev_rate;
   logic [7:0]  dev_local_high;
   logic [7:0]  dev_local_low;
   logic [15:0] dev_remote_high;
   logic [15:0] dev_remote_low;
   logic [15:0] dev_offset;
   logic [7:0]  dev_remote_crit;
   logic [7:0]  dev_local_crit;
   logic [7:0]  dev_crit_hyst;
   logic [7:0]  dev_alert_count;
   logic [7:0]  dev_local_reading;
   logic [15:0] dev_remote_reading;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A generous ceiling, far beyond what the slowest legal run needs, so
   // reaching it can only mean a hang.
   initial begin
      #2400000;
      $display("Simulation FAILED");
      $finish;
   end

   // Works out the reply to one bus event and moves the register copy on.
   // A write-transfer start only arms the pointer load; the first written
   // byte after it becomes the pointer and is not itself a data byte. Every
   // data byte and every read advances the pointer, wrapping at 256, whether
   // or not the address decodes.
   function automatic rsp_type bus_event_outcome(req_type ev);
      rsp_type r;
      r = '0;
      case (ev.operation)
         OP_START: arm_pointer = 1'b1;
         OP_WRITE: begin
            if (arm_pointer) begin
               reg_ptr = ev.data_byte;
               arm_pointer = 1'b0;
            end else begin
               case (reg_ptr)
                  ADDR_CONFIG_WR:         dev_config = ev.data_byte;
                  ADDR_RATE_WR:           dev_rate = ev.data_byte;
                  ADDR_LOCAL_HIGH_WR:     dev_local_high = ev.data_byte;
                  ADDR_LOCAL_LOW_WR:      dev_local_low = ev.data_byte;
                  ADDR_REMOTE_HIGH_HI_WR: dev_remote_high[15:8] = ev.data_byte;
                  ADDR_REMOTE_LOW_HI_WR:  dev_remote_low[15:8] = ev.data_byte;
                  ADDR_ONE_SHOT:          ;
                  ADDR_OFFSET_HI:         dev_offset[15:8] = ev.data_byte;
                  ADDR_OFFSET_LO:         dev_offset[7:0] = ev.data_byte;
                  ADDR_REMOTE_HIGH_LO:    dev_remote_high[7:0] = ev.data_byte;
                  ADDR_REMOTE_LOW_LO:     dev_remote_low[7:0] = ev.data_byte;
                  ADDR_REMOTE_CRIT:       dev_remote_crit = ev.data_byte;
                  ADDR_LOCAL_CRIT:        dev_local_crit = ev.data_byte;
                  ADDR_CRIT_HYST:         dev_crit_hyst = ev.data_byte;
                  ADDR_ALERT_COUNT:       dev_alert_count = ev.data_byte;
                  default:                r.bad_address = 1'b1;
               endcase
               reg_ptr = reg_ptr + 8'd1;
            end
         end
         OP_READ: begin
            // A read neither looks at nor clears the pending pointer load.
            r.read_valid = 1'b1;
            case (reg_ptr)
               ADDR_LOCAL_TEMP:        r.read_data = dev_local_reading;
               ADDR_REMOTE_TEMP_HI:    r.read_data = dev_remote_reading[15:8];
               ADDR_STATUS:            r.read_data = 8'h00;
               ADDR_CONFIG_RD:         r.read_data = dev_config;
               ADDR_RATE_RD:           r.read_data = dev_rate;
               ADDR_LOCAL_HIGH_RD:     r.read_data = dev_local_high;
               ADDR_LOCAL_LOW_RD:      r.read_data = dev_local_low;
               ADDR_REMOTE_HIGH_HI_RD: r.read_data = dev_remote_high[15:8];
               ADDR_REMOTE_LOW_HI_RD:  r.read_data = dev_remote_low[15:8];
               ADDR_REMOTE_TEMP_LO:    r.read_data = dev_remote_reading[7:0];
               ADDR_OFFSET_HI:         r.read_data = dev_offset[15:8];
               ADDR_OFFSET_LO:         r.read_data = dev_offset[7:0];
               ADDR_REMOTE_HIGH_LO:    r.read_data = dev_remote_high[7:0];
               ADDR_REMOTE_LOW_LO:     r.read_data = dev_remote_low[7:0];
               ADDR_REMOTE_CRIT:       r.read_data = dev_remote_crit;
               ADDR_LOCAL_CRIT:        r.read_data = dev_local_crit;
               ADDR_CRIT_HYST:         r.read_data = dev_crit_hyst;
               ADDR_ALERT_COUNT:       r.read_data = dev_alert_count;
               ADDR_MAKER_ID:          r.read_data = MAKER_CODE;
               ADDR_REVISION_ID:       r.read_data = REVISION_CODE;
               default:                r.bad_address = 1'b1;
            endcase
            reg_ptr = reg_ptr + 8'd1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Driver. The sender offers beats in bursts of random length separated by
   // random gaps, some of them empty so that long unbroken stretches occur.
   // While a beat is stalled, neither valid nor the payload is touched, and
   // each signal receives at most one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         // The beat on the bus, if any, is accepted at this edge.
         if (req_valid)
            pending_replies.push_back(bus_event_outcome(req_payload));
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_events.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= bus_events.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. Every result beat is held against the oldest outstanding
   // reply. The stall pattern is picked anew at regular intervals: no stall,
   // light random, heavy random, or a fixed one-in-three rhythm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("Unexpected result beat: data %h valid %b bad %b",
                           rsp_payload.read_data, rsp_payload.read_valid,
                           rsp_payload.bad_address);
            end else begin
               rsp_type want;
               want = pending_replies.pop_front();
               if (rsp_payload.read_data !== want.read_data
                   || rsp_payload.read_valid !== want.read_valid
                   || rsp_payload.bad_address !== want.bad_address) begin
                  failures++;
                  if (failures <= 10)
                     $display("Result mismatch at %0t: ", $realtime,
                              "expected data %h valid %b bad %b, ",
                              want.read_data, want.read_valid, want.bad_address,
                              "got data %h valid %b bad %b",
                              rsp_payload.read_data, rsp_payload.read_valid,
                              rsp_payload.bad_address);
               end
            end
         end
         stall_tick++;
         if (stall_tick % 48 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (stall_tick % 3 == 0);
         endcase
      end
   end

   task automatic push_event(input op_type op, input logic [7:0] b);
      req_type ev;
      ev.operation = op;
      ev.data_byte = b;
      bus_events.push_back(ev);
      if (op != OP_OTHER)
         issued++;
   endtask

   // One bus transaction. Most are well formed: a start, a pointer byte, and
   // a run of data writes, reads or both. A few read between the start and
   // the pointer byte, and one in ten is plain noise.
   task automatic add_transfer();
      int kind;
      int style;
      int n;
      logic [7:0] ptr;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) push_event(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0:       ptr = 8'($urandom_range(248, 255));
            1:       ptr = 8'($urandom_range(0, 255));
            default: ptr = reg_map[$urandom_range(0, reg_map.size() - 1)];
         endcase
         push_event(OP_START, 8'($urandom_range(0, 255)));
         if (kind == 1)
            push_event(OP_READ, 8'($urandom_range(0, 255)));
         push_event(OP_WRITE, ptr);
         n = $urandom_range(0, 6);
         style = $urandom_range(0, 2);
         repeat (n) begin
            if ($urandom_range(0, 15) == 0)
               push_event(OP_OTHER, 8'($urandom_range(0, 255)));
            if (style == 0 || (style == 2 && $urandom_range(0, 1) == 0))
               push_event(OP_WRITE, 8'($urandom_range(0, 255)));
            else
               push_event(OP_READ, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // One APB transfer: setup cycle, then access until pready is seen high.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] a,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= a;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Loads both readings, mirrors them in the register copy and reads them
   // back over the same port.
   task automatic set_readings(input logic [7:0] lr, input logic [15:0] rr);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {CSR_IDX_LOCAL, 2'b00}, {24'd0, lr}, rd);
      dev_local_reading = lr;
      csr_access(1'b1, {CSR_IDX_REMOTE, 2'b00}, {16'd0, rr}, rd);
      dev_remote_reading = rr;
      csr_access(1'b0, {CSR_IDX_LOCAL, 2'b00}, '0, rd);
      if (rd !== {24'd0, lr}) begin
         failures++;
         if (failures <= 10)
            $display("Local reading readback: expected %h, got %h", lr, rd);
      end
      csr_access(1'b0, {CSR_IDX_REMOTE, 2'b00}, '0, rd);
      if (rd !== {16'd0, rr}) begin
         failures++;
         if (failures <= 10)
            $display("Remote reading readback: expected %h, got %h", rr, rd);
      end
   endtask

   // Waits for every queued beat to go out and every reply to come back,
   // then lets the two pipeline stages settle. Sampling on the falling edge
   // keeps this clear of the driver and monitor.
   task automatic wait_quiet();
      while (bus_events.size() != 0 || req_valid || pending_replies.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [7:0]  lr;
      logic [15:0] rr;
      int phase;

      reg_map = '{ADDR_LOCAL_TEMP, ADDR_REMOTE_TEMP_HI, ADDR_STATUS, ADDR_CONFIG_RD,
                  ADDR_RATE_RD, ADDR_LOCAL_HIGH_RD, ADDR_LOCAL_LOW_RD,
                  ADDR_REMOTE_HIGH_HI_RD, ADDR_REMOTE_LOW_HI_RD, ADDR_CONFIG_WR,
                  ADDR_RATE_WR, ADDR_LOCAL_HIGH_WR, ADDR_LOCAL_LOW_WR,
                  ADDR_REMOTE_HIGH_HI_WR, ADDR_REMOTE_LOW_HI_WR, ADDR_ONE_SHOT,
                  ADDR_REMOTE_TEMP_LO, ADDR_OFFSET_HI, ADDR_OFFSET_LO,
                  ADDR_REMOTE_HIGH_LO, ADDR_REMOTE_LOW_LO, ADDR_REMOTE_CRIT,
                  ADDR_LOCAL_CRIT, ADDR_CRIT_HYST, ADDR_ALERT_COUNT,
                  ADDR_MAKER_ID, ADDR_REVISION_ID};

      // Power-on contents of the register copy.
      arm_pointer = 1'b1;
      reg_ptr = 8'h00;
      dev_config = CONFIG_RESET;
      dev_rate = RATE_RESET;
      dev_local_high = LOCAL_HIGH_RESET;
      dev_local_low = LOCAL_LOW_RESET;
      dev_remote_high = REMOTE_HIGH_RESET;
      dev_remote_low = REMOTE_LOW_RESET;
      dev_offset = REMOTE_OFFSET_RESET;
      dev_remote_crit = REMOTE_CRIT_RESET;
      dev_local_crit = LOCAL_CRIT_RESET;
      dev_crit_hyst = CRIT_HYST_RESET;
      dev_alert_count = ALERT_COUNT_RESET;
      dev_local_reading = LOCAL_READING_RESET;
      dev_remote_reading = REMOTE_READING_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run on the power-on readings.
      // An ignored event, then a read before any pointer has been loaded.
      push_event(OP_OTHER, 8'hFF);
      push_event(OP_READ, 8'hFF);
      // Identification bytes, and the pointer wrapping from the top back to
      // the local reading.
      push_event(OP_START, 8'h00);
      push_event(OP_WRITE, ADDR_MAKER_ID);
      push_event(OP_READ, 8'h00);
      push_event(OP_READ, 8'hA5);
      push_event(OP_READ, 8'h5A);
      // Extreme data bytes into the config and rate registers, read back.
      push_event(OP_START, 8'hFF);
      push_event(OP_WRITE, ADDR_CONFIG_WR);
      push_event(OP_WRITE, 8'hFF);
      push_event(OP_WRITE, 8'h00);
      push_event(OP_START, 8'h00);
      push_event(OP_WRITE, ADDR_CONFIG_RD);
      push_event(OP_READ, 8'h00);
      push_event(OP_READ, 8'h00);
      // Unmapped write and unmapped read: flagged, pointer still moves on.
      push_event(OP_START, 8'h00);
      push_event(OP_WRITE, 8'h23);
      push_event(OP_WRITE, 8'hA5);
      push_event(OP_READ, 8'h00);
      // A read straight after a start leaves the pointer load armed, so the
      // next byte still lands in the pointer; then the one-shot write.
      push_event(OP_START, 8'h00);
      push_event(OP_READ, 8'h00);
      push_event(OP_WRITE, ADDR_ONE_SHOT);
      push_event(OP_WRITE, 8'h5A);
      wait_quiet();

      // Random part: five settings of the readings, the extremes among them.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       begin lr = 8'h00; rr = 16'h0000; end
            1:       begin lr = 8'hFF; rr = 16'hFFFF; end
            2:       begin lr = 8'h80; rr = 16'h8001; end
            default: begin
               lr = 8'($urandom_range(0, 255));
               rr = 16'($urandom_range(0, 65535));
            end
         endcase
         set_readings(lr, rr);
         issued = 0;
         while (issued < 160)
            add_transfer();
         wait_quiet();
      end

      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
